FILE: sv/lgge_pkg.sv
// Shared types and constants for the toroidal life grid engine.
// No dependencies; imported by every module of the block.
package lgge_pkg;

   localparam int LGGE_MAX_COLS = 64;
   localparam int LGGE_MAX_ROWS = 64;

   localparam int OP_W       = 2;
   localparam int ROW_IDX_W  = 6;
   localparam int ROW_BITS_W = 64;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 7;

   localparam logic [OP_W-1:0] OP_WRITE = 2'd0;
   localparam logic [OP_W-1:0] OP_READ  = 2'd1;
   localparam logic [OP_W-1:0] OP_STEP  = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_COLS = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_ROWS = 1'b1;

   localparam logic [CSR_DATA_W-1:0] COLS_RESET = 7'd45;
   localparam logic [CSR_DATA_W-1:0] ROWS_RESET = 7'd45;

   localparam int DIM_MIN = 3;

   localparam logic [3:0] BIRTH_COUNT   = 4'd3;
   localparam logic [3:0] SURVIVE_COUNT = 4'd2;

   typedef struct packed {
      logic rd_en;
      logic user_rd;
      logic user_wr;
      logic step_wr;
      logic shift_en;
      logic shift_save;
      logic save_row0;
      logic res_clr;
      logic res_load;
      logic rsp_load;
   } lgge_cmd_type;

endpackage

FILE: sv/lgge_dp.sv
// Datapath: config registers, row memory with row valid bits, neighbor row window,
// next-generation logic and response register. Uses lgge_pkg; driven by lgge_ctrl.
module lgge_dp
   import lgge_pkg::*;
#(
   parameter int MAX_COLS = LGGE_MAX_COLS,
   parameter int MAX_ROWS = LGGE_MAX_ROWS
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_we,
   input  logic [CSR_IDX_W-1:0]          csr_index,
   input  logic [CSR_DATA_W-1:0]         csr_wdata,
   input  logic [ROW_IDX_W-1:0]          req_row_index,
   input  logic [ROW_BITS_W-1:0]         req_row_bits,
   input  lgge_cmd_type                  cmd,
   input  logic [$clog2(MAX_ROWS)-1:0]   step_rd_addr,
   input  logic [$clog2(MAX_ROWS)-1:0]   step_wr_addr,
   output logic [$clog2(MAX_ROWS+1)-1:0] rows_act,
   output logic [ROW_BITS_W-1:0]         rsp_read_bits
);

   localparam int CW   = MAX_COLS;
   localparam int AW   = $clog2(MAX_ROWS);
   localparam int RW   = $clog2(MAX_ROWS + 1);
   localparam int CAW  = $clog2(MAX_COLS + 1);
   localparam int CIW  = $clog2(MAX_COLS);
   localparam int CMPW = (RW > ROW_IDX_W) ? RW : ROW_IDX_W;

   logic [CSR_DATA_W-1:0] cols_ff;
   logic [CSR_DATA_W-1:0] rows_ff;
   logic [CAW-1:0]        cols_act;
   logic [CIW-1:0]        last_col;
   logic [CW-1:0]         col_mask;
   logic                  row_ok;

   logic [CW-1:0]         grid_mem [MAX_ROWS];
   logic [MAX_ROWS-1:0]   vld_ff;
   logic                  wr_en;
   logic [AW-1:0]         wr_addr;
   logic [CW-1:0]         wr_data;
   logic [AW-1:0]         rd_addr;
   logic [CW-1:0]         rd_data_ff;
   logic                  rd_vld_ff;
   logic                  rd_ok_ff;
   logic [CW-1:0]         rd_word;

   logic [CW-1:0]         win_up_ff;
   logic [CW-1:0]         win_mid_ff;
   logic [CW-1:0]         win_dn_ff;
   logic [CW-1:0]         row0_ff;
   logic [CW-1:0]         shift_in;
   logic [CW-1:0]         next_row;
   logic [CW-1:0]         res_ff;
   logic [CW-1:0]         rsp_bits_ff;

   function automatic logic [CW-1:0] left_of(input logic [CW-1:0] w,
                                             input logic [CIW-1:0] last);
      left_of = {w[CW-2:0], w[last]};
   endfunction

   function automatic logic [CW-1:0] right_of(input logic [CW-1:0] w,
                                              input logic [CIW-1:0] last);
      logic [CW-1:0] r;
      r = {1'b0, w[CW-1:1]};
      r[last] = w[0];
      right_of = r;
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         cols_ff <= COLS_RESET;
         rows_ff <= ROWS_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_COLS: cols_ff <= csr_wdata;
            CSR_ROWS: rows_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      if (int'(rows_ff) < DIM_MIN) begin
         rows_act = RW'(DIM_MIN);
      end else if (int'(rows_ff) > MAX_ROWS) begin
         rows_act = RW'(MAX_ROWS);
      end else begin
         rows_act = RW'(rows_ff);
      end
      if (int'(cols_ff) < DIM_MIN) begin
         cols_act = CAW'(DIM_MIN);
      end else if (int'(cols_ff) > MAX_COLS) begin
         cols_act = CAW'(MAX_COLS);
      end else begin
         cols_act = CAW'(cols_ff);
      end
      last_col = CIW'(cols_act - CAW'(1));
      for (int c = 0; c < CW; c++) begin
         col_mask[c] = (c < int'(cols_act));
      end
   end

   assign row_ok = CMPW'(req_row_index) < CMPW'(rows_act);

   assign wr_en   = (cmd.user_wr && row_ok) || cmd.step_wr;
   assign wr_addr = cmd.step_wr ? step_wr_addr : AW'(req_row_index);
   assign wr_data = cmd.step_wr ? next_row : (req_row_bits[CW-1:0] & col_mask);
   assign rd_addr = cmd.user_rd ? AW'(req_row_index) : step_rd_addr;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         grid_mem[wr_addr] <= wr_data;
      end
      if (cmd.rd_en) begin
         rd_data_ff <= grid_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff    <= '0;
         rd_vld_ff <= 1'b0;
      end else begin
         if (wr_en) begin
            vld_ff[wr_addr] <= 1'b1;
         end
         if (cmd.rd_en) begin
            rd_vld_ff <= vld_ff[rd_addr];
         end
      end
   end

   assign rd_word  = rd_vld_ff ? rd_data_ff : '0;
   assign shift_in = cmd.shift_save ? row0_ff : rd_word;

   always_ff @(posedge clock) begin
      if (cmd.user_rd) begin
         rd_ok_ff <= row_ok;
      end
      if (cmd.shift_en) begin
         win_up_ff  <= win_mid_ff;
         win_mid_ff <= win_dn_ff;
         win_dn_ff  <= shift_in;
      end
      if (cmd.save_row0) begin
         row0_ff <= rd_word;
      end
      if (cmd.res_clr) begin
         res_ff <= '0;
      end else if (cmd.res_load) begin
         res_ff <= rd_ok_ff ? (rd_word & col_mask) : '0;
      end
      if (cmd.rsp_load) begin
         rsp_bits_ff <= res_ff;
      end
   end

   always_comb begin
      logic [CW-1:0] up_l;
      logic [CW-1:0] up_r;
      logic [CW-1:0] mid_l;
      logic [CW-1:0] mid_r;
      logic [CW-1:0] dn_l;
      logic [CW-1:0] dn_r;
      logic [3:0]    n;
      up_l  = left_of(win_up_ff, last_col);
      up_r  = right_of(win_up_ff, last_col);
      mid_l = left_of(win_mid_ff, last_col);
      mid_r = right_of(win_mid_ff, last_col);
      dn_l  = left_of(win_dn_ff, last_col);
      dn_r  = right_of(win_dn_ff, last_col);
      for (int c = 0; c < CW; c++) begin
         n = 4'(up_l[c]) + 4'(win_up_ff[c]) + 4'(up_r[c])
           + 4'(mid_l[c]) + 4'(mid_r[c])
           + 4'(dn_l[c]) + 4'(win_dn_ff[c]) + 4'(dn_r[c]);
         next_row[c] = col_mask[c]
                     && ((n == BIRTH_COUNT) || (win_mid_ff[c] && (n == SURVIVE_COUNT)));
      end
   end

   assign rsp_read_bits = ROW_BITS_W'(rsp_bits_ff);

endmodule

FILE: sv/lgge_ctrl.sv
// Controller: request decode, generation sweep sequencer and response valid.
// Uses lgge_pkg; issues lgge_cmd_type commands to lgge_dp.
module lgge_ctrl
   import lgge_pkg::*;
#(
   parameter int MAX_ROWS = LGGE_MAX_ROWS
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [OP_W-1:0]               req_op,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   input  logic [$clog2(MAX_ROWS+1)-1:0] rows_act,
   output lgge_cmd_type                  cmd,
   output logic [$clog2(MAX_ROWS)-1:0]   step_rd_addr,
   output logic [$clog2(MAX_ROWS)-1:0]   step_wr_addr
);

   localparam int AW   = $clog2(MAX_ROWS);
   localparam int CNTW = $clog2(MAX_ROWS + 4);

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_READ = 2'd1;
   localparam logic [1:0] S_STEP = 2'd2;
   localparam logic [1:0] S_DONE = 2'd3;

   logic [1:0]      state_ff;
   logic [1:0]      state_in;
   logic [CNTW-1:0] cnt_ff;
   logic [CNTW-1:0] cnt_in;
   logic [CNTW-1:0] r_ext;
   logic            rsp_valid_ff;

   assign r_ext     = CNTW'(rows_act);
   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      cmd          = '0;
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      step_rd_addr = '0;
      step_wr_addr = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               case (req_op)
                  OP_WRITE: begin
                     cmd.user_wr = 1'b1;
                     cmd.res_clr = 1'b1;
                     state_in    = S_DONE;
                  end
                  OP_READ: begin
                     cmd.rd_en   = 1'b1;
                     cmd.user_rd = 1'b1;
                     state_in    = S_READ;
                  end
                  OP_STEP: begin
                     cnt_in   = '0;
                     state_in = S_STEP;
                  end
                  default: begin
                     cmd.res_clr = 1'b1;
                     state_in    = S_DONE;
                  end
               endcase
            end
         end
         S_READ: begin
            cmd.res_load = 1'b1;
            state_in     = S_DONE;
         end
         S_STEP: begin
            cmd.rd_en      = (cnt_ff <= r_ext);
            step_rd_addr   = (cnt_ff == '0) ? AW'(r_ext - CNTW'(1)) : AW'(cnt_ff - CNTW'(1));
            cmd.shift_en   = (cnt_ff >= CNTW'(1)) && (cnt_ff <= r_ext + CNTW'(2));
            cmd.shift_save = (cnt_ff == r_ext + CNTW'(2));
            cmd.save_row0  = (cnt_ff == CNTW'(2));
            cmd.step_wr    = (cnt_ff >= CNTW'(4));
            step_wr_addr   = AW'(cnt_ff - CNTW'(4));
            cnt_in         = cnt_ff + CNTW'(1);
            if (cnt_ff == r_ext + CNTW'(3)) begin
               cmd.res_clr = 1'b1;
               state_in    = S_DONE;
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.rsp_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         if (cmd.rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

`ifndef SYNTHESIS
   assert property (@(posedge clock) disable iff (reset)
      (cmd.step_wr && cmd.rd_en) |-> (step_wr_addr != step_rd_addr))
      else $error("sweep writes the row it is reading");

   assert property (@(posedge clock) disable iff (reset)
      (cmd.rsp_load && rsp_valid_ff) |-> rsp_ready)
      else $error("response overwritten before it was taken");

   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_STEP) |-> (cnt_ff <= r_ext + CNTW'(3)))
      else $error("sweep counter ran past the last row");

   assert property (@(posedge clock) disable iff (reset)
      cmd.step_wr |-> $past(cmd.shift_en))
      else $error("row written before the window was filled");
`endif

endmodule

FILE: sv/life_grid_generation_engine.sv
// Toroidal B3/S23 life grid engine: holds up to MAX_ROWS rows of MAX_COLS cells.
// Request channel (req_valid/req_ready): req_op writes a row, reads a row or advances
// the active grid one generation; req_row_index and req_row_bits carry the row.
// Response channel (rsp_valid/rsp_ready): one rsp_read_bits per request, the row for
// a read and zero otherwise. csr_we/csr_index/csr_wdata set cols_in_use (index 0)
// and rows_in_use (index 1); write them only while no request is in flight.
// An advance sweeps every active row once through the two-port row memory, with three
// neighbor row registers and a copy of row 0 for the wrap. A new request is taken
// the cycle after the previous response is loaded into the output register.
// If the receiver stalls, the response holds in the output register and the engine
// may accept one more request, then waits with that result until the slot frees.
// Reset: all cells dead at once through per-row valid bits, no clearing pass;
// both size registers return to 45.
// Uses lgge_pkg, lgge_ctrl and lgge_dp.
module life_grid_generation_engine
   import lgge_pkg::*;
#(
   parameter int MAX_COLS = LGGE_MAX_COLS,
   parameter int MAX_ROWS = LGGE_MAX_ROWS
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [OP_W-1:0]       req_op,
   input  logic [ROW_IDX_W-1:0]  req_row_index,
   input  logic [ROW_BITS_W-1:0] req_row_bits,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [ROW_BITS_W-1:0] rsp_read_bits,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int AW = $clog2(MAX_ROWS);
   localparam int RW = $clog2(MAX_ROWS + 1);

   lgge_cmd_type  cmd;
   logic [AW-1:0] step_rd_addr;
   logic [AW-1:0] step_wr_addr;
   logic [RW-1:0] rows_act;

   lgge_ctrl #(
      .MAX_ROWS (MAX_ROWS)
   ) u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_op       (req_op),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rows_act     (rows_act),
      .cmd          (cmd),
      .step_rd_addr (step_rd_addr),
      .step_wr_addr (step_wr_addr)
   );

   lgge_dp #(
      .MAX_COLS (MAX_COLS),
      .MAX_ROWS (MAX_ROWS)
   ) u_dp (
      .clock         (clock),
      .reset         (reset),
      .csr_we        (csr_we),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .req_row_index (req_row_index),
      .req_row_bits  (req_row_bits),
      .cmd           (cmd),
      .step_rd_addr  (step_rd_addr),
      .step_wr_addr  (step_wr_addr),
      .rows_act      (rows_act),
      .rsp_read_bits (rsp_read_bits)
   );

endmodule
